FILE: sv/mlta_pkg.sv
// Shared types, codes and default constants of the MAC learning table.
`timescale 1ns / 1ps

package mlta_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int PORT_BITS_DEF  = 4;
    localparam int STAMP_BITS_DEF = 16;

    localparam int MAC_W   = 48;
    localparam int FUNC_W  = 2;
    localparam int AGE_W   = 15;
    localparam int AGED_W  = 7;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 15'd30;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_LEARN  = 2'd1,
        FUNC_TICK   = 2'd2
    } t_func;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic start;
        logic scan;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

FILE: sv/mlta_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mlta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/mlta_ctrl.sv
// Controller state machine of the MAC learning table.
`timescale 1ns / 1ps

module mlta_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [mlta_pkg::FUNC_W-1:0]  i_in_func,
    input  mlta_pkg::t_sts               i_sts,
    output mlta_pkg::t_cmd               o_cmd,
    output logic                         o_in_ready
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   func_scans;

    // Unused function codes skip the scan and report all zeros.
    assign func_scans = (i_in_func == mlta_pkg::FUNC_LOOKUP) ||
                        (i_in_func == mlta_pkg::FUNC_LEARN)  ||
                        (i_in_func == mlta_pkg::FUNC_TICK);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = func_scans ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/mlta_dpath.sv
// Datapath of the MAC learning table: table RAM, scan pipeline and result register.
`timescale 1ns / 1ps

module mlta_dpath #(
    parameter int ENTRIES    = mlta_pkg::ENTRIES_DEF,
    parameter int PORT_BITS  = mlta_pkg::PORT_BITS_DEF,
    parameter int STAMP_BITS = mlta_pkg::STAMP_BITS_DEF,
    localparam int IN_W  = ((mlta_pkg::MAC_W + PORT_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((PORT_BITS + mlta_pkg::AGED_W + 2 + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mlta_pkg::t_cmd               i_cmd,
    output mlta_pkg::t_sts               o_sts,
    input  logic [IN_W-1:0]              i_s_tdata,
    input  logic [mlta_pkg::FUNC_W-1:0]  i_s_tuser,
    input  logic                         i_cfg_we,
    input  logic [mlta_pkg::AGE_W-1:0]   i_cfg_wdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [OUT_W-1:0]             o_m_tdata
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int MAC_W   = mlta_pkg::MAC_W;
    localparam int AGED_W  = mlta_pkg::AGED_W;
    localparam int WORD_W  = 1 + MAC_W + PORT_BITS + STAMP_BITS;
    localparam int CMP_W   = (STAMP_BITS > mlta_pkg::AGE_W) ? STAMP_BITS : mlta_pkg::AGE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Control registers.
    logic [IDX_W-1:0]              r_addr;
    logic                          r_iss;
    logic                          r_cmp_vld;
    logic                          r_found;
    logic                          r_free_found;
    logic [AGED_W-1:0]             r_count;
    logic [STAMP_BITS-1:0]         r_now;
    logic [mlta_pkg::AGE_W-1:0]    r_age_limit;
    logic                          r_out_valid;

    // Payload registers.
    logic [mlta_pkg::FUNC_W-1:0]   r_func;
    logic [MAC_W-1:0]              r_mac;
    logic [PORT_BITS-1:0]          r_port_in;
    logic [IDX_W-1:0]              r_cmp_idx;
    logic [IDX_W-1:0]              r_hit_idx;
    logic [IDX_W-1:0]              r_free_idx;
    logic [PORT_BITS-1:0]          r_port;
    logic [OUT_W-1:0]              r_out_data;

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [WORD_W-1:0]             ram_wdata;
    logic                          ram_re;
    logic [WORD_W-1:0]             rd_data;

    logic                          rd_valid;
    logic [MAC_W-1:0]              rd_mac;
    logic [PORT_BITS-1:0]          rd_port;
    logic [STAMP_BITS-1:0]         rd_stamp;
    logic [STAMP_BITS-1:0]         age;
    logic                          is_lookup;
    logic                          is_learn;
    logic                          is_tick;
    logic                          hit_now;
    logic                          aged_now;
    logic                          cmp_last;
    logic                          out_hit;
    logic [PORT_BITS-1:0]          out_port;
    logic                          out_status;

    // Word layout from the top: valid, address, port, time stamp.
    assign rd_valid = rd_data[WORD_W-1];
    assign rd_mac   = rd_data[WORD_W-2 -: MAC_W];
    assign rd_port  = rd_data[STAMP_BITS +: PORT_BITS];
    assign rd_stamp = rd_data[STAMP_BITS-1:0];

    assign is_lookup = (r_func == mlta_pkg::FUNC_LOOKUP);
    assign is_learn  = (r_func == mlta_pkg::FUNC_LEARN);
    assign is_tick   = (r_func == mlta_pkg::FUNC_TICK);

    assign age      = r_now - rd_stamp;
    assign hit_now  = r_cmp_vld && rd_valid && (rd_mac == r_mac);
    assign aged_now = r_cmp_vld && rd_valid && (CMP_W'(age) >= CMP_W'(r_age_limit));
    assign cmp_last = (r_cmp_idx == LAST_IDX);

    // A lookup or learn stops at its first match, which is the lowest slot.
    assign o_sts.scan_done  = r_cmp_vld && (cmp_last || (hit_now && !is_tick));
    assign o_sts.clear_done = (r_addr == LAST_IDX);
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    assign ram_re = i_cmd.scan && r_iss;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        if (i_cmd.clear) begin
            ram_we = 1'b1;
        end else if (i_cmd.scan && is_tick && aged_now) begin
            ram_we    = 1'b1;
            ram_waddr = r_cmp_idx;
            ram_wdata = {1'b0, rd_data[WORD_W-2:0]};
        end else if (i_cmd.finish && is_learn && (r_found || r_free_found)) begin
            ram_we    = 1'b1;
            ram_waddr = r_found ? r_hit_idx : r_free_idx;
            ram_wdata = {1'b1, r_mac, r_port_in, r_now};
        end
    end

    assign out_hit    = r_found;
    assign out_port   = (is_lookup && r_found) ? r_port : '0;
    assign out_status = is_learn && !r_found && !r_free_found;

    mlta_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_iss        <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_count      <= '0;
            r_now        <= '0;
            r_age_limit  <= mlta_pkg::AGE_LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_age_limit <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_addr <= o_sts.clear_done ? '0 : r_addr + 1'b1;
            end
            if (i_cmd.start) begin
                r_addr       <= '0;
                r_iss        <= 1'b1;
                r_cmp_vld    <= 1'b0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
                r_count      <= '0;
                if (i_s_tuser == mlta_pkg::FUNC_TICK) begin
                    r_now <= r_now + 1'b1;
                end
            end
            if (i_cmd.scan) begin
                r_cmp_vld <= r_iss;
                if (r_iss) begin
                    if (r_addr == LAST_IDX) begin
                        r_iss <= 1'b0;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                if (hit_now && !is_tick) begin
                    r_found <= 1'b1;
                end
                if (r_cmp_vld && !rd_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
                if (is_tick && aged_now) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func    <= i_s_tuser;
            r_mac     <= i_s_tdata[MAC_W-1:0];
            r_port_in <= i_s_tdata[MAC_W +: PORT_BITS];
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_addr;
            if (hit_now && !is_tick) begin
                r_hit_idx <= r_cmp_idx;
                r_port    <= rd_port;
            end
            if (r_cmp_vld && !rd_valid && !r_free_found) begin
                r_free_idx <= r_cmp_idx;
            end
        end
        if (i_cmd.finish) begin
            r_out_data <= OUT_W'({out_status, r_count, out_port, out_hit});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

FILE: sv/mac_learning_table_aging_unit.sv
// Top level of the MAC learning table with aging.
`timescale 1ns / 1ps

// A fully associative table of ENTRIES slots maps 48-bit addresses to ports.
// Each operation scans the table RAM one entry per cycle through its single
// read port, so a full scan covers every slot (a miss, a new learn, any tick);
// a lookup or learn that hits slot k stops there, and an unused function code
// skips the scan. After reset a clearing pass empties the table; no input
// beat is accepted during it, while age limit writes are taken at any time.
// A finished result sits in an output register, so the next beat is accepted
// while the result waits to be taken.
module mac_learning_table_aging_unit #(
    parameter int ENTRIES    = mlta_pkg::ENTRIES_DEF,
    parameter int PORT_BITS  = mlta_pkg::PORT_BITS_DEF,
    parameter int STAMP_BITS = mlta_pkg::STAMP_BITS_DEF,
    localparam int IN_W  = ((mlta_pkg::MAC_W + PORT_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((PORT_BITS + mlta_pkg::AGED_W + 2 + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // Fields from bit 0: mac_addr, port_in, zero fill.
    input  logic [IN_W-1:0]              i_s_tdata,
    // Fields from bit 0: func.
    input  logic [mlta_pkg::FUNC_W-1:0]  i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // Fields from bit 0: hit, port_out, aged_count, status, zero fill.
    output logic [OUT_W-1:0]             o_m_tdata,
    input  logic                         i_cfg_we,
    input  logic [mlta_pkg::AGE_W-1:0]   i_cfg_wdata
);

    mlta_pkg::t_cmd cmd;
    mlta_pkg::t_sts sts;

    mlta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_func  (i_s_tuser),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_s_tready)
    );

    mlta_dpath #(
        .ENTRIES    (ENTRIES),
        .PORT_BITS  (PORT_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // No beat is taken while the table is being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !o_s_tready)
        else $error("input ready during clearing pass");

    // Every accepted beat starts an operation in the datapath.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> cmd.start)
        else $error("accepted beat did not start an operation");

    // A finished operation shows its result in the next cycle.
    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_m_tvalid)
        else $error("finished operation did not present a result");

    // A dropped learn never reports a hit.
    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[PORT_BITS + mlta_pkg::AGED_W + 1]))
        else $error("result reports both hit and table full");

endmodule
